FILE: rtl/core/gnsm_pkg.sv
// gnsm_pkg: shared sizes, types and helpers for the greedy nearest slot matcher
// used by gnsm_cell and greedy_nearest_slot_matcher; no dependencies
package gnsm_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int COORD_BITS = 16;

    // stored coordinate width, capped at the 16-bit input field
    localparam int CoordW = (COORD_BITS > 16) ? 16 : COORD_BITS;
    localparam int DiffW  = CoordW + 1;
    localparam int SqW    = 2 * DiffW;
    localparam int DistW  = SqW + 1;
    localparam int IdxW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CntW   = $clog2(NUM_SLOTS + 1);

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic [SqW-1:0]           sq_t;
    typedef logic [DistW-1:0]         dist_t;
    typedef logic [IdxW-1:0]          idx_t;

    // best candidate handed from cell to cell
    typedef struct packed {
        logic  found;
        dist_t dist_sq;
        idx_t  idx;
    } best_t;

    // state update broadcast to every cell at the end of a transaction
    typedef struct packed {
        logic en;
        logic eof;
        logic wr;
        idx_t idx;
    } commit_t;

    // per-cell status bits seen by the controller
    typedef struct packed {
        logic used;
        logic claimed;
        logic active;
    } cell_stat_t;

endpackage

FILE: rtl/core/greedy_nearest_slot_matcher.sv
// greedy_nearest_slot_matcher: top level, controller plus the chain of slot cells
// depends on gnsm_pkg and gnsm_cell
//
// One transaction in gives one transaction out. A centroid (kind 0) goes to the
// unclaimed slot nearest by squared distance, lowest index on a tie; with no
// unclaimed slot a fresh slot is allocated, and with the table full overflow is
// set and nothing is stored. End of frame (kind 1) drops every unclaimed slot
// from the active mask and clears all claims. Each transaction runs in steps:
// every cell computes its squared distance at once, the squares and then their
// sum each behind a register; then the best candidate walks down the chain
// through the register of each cell; then comes the commit, which waits while a
// held result is stalled on the output. The input is taken again only after the
// commit, so a new transaction is not accepted before the last one is committed.
// One transaction is in flight at a time; the result register lets the next one
// be accepted while a result still waits to be taken.
module greedy_nearest_slot_matcher
    import gnsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic signed [15:0] centroid_x,
    input  logic signed [15:0] centroid_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         slot_index,
    output logic               new_slot,
    output logic               overflow,
    output logic [15:0]        active_mask
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // count at which the distances have settled and the candidate has passed every cell
    localparam int LastCnt = NUM_SLOTS + 2;
    localparam int SeqW    = $clog2(LastCnt + 1);
    localparam int MaskW   = (NUM_SLOTS > 16) ? NUM_SLOTS : 16;
    localparam int PadIdxW = (IdxW > 4) ? IdxW : 4;

    logic            state_reg;
    logic            state_next;
    logic [SeqW-1:0] cnt_reg;
    logic [SeqW-1:0] cnt_next;
    logic [CntW-1:0] in_use_reg;
    logic [CntW-1:0] in_use_next;
    logic            kind_reg;
    coord_t          qx_reg;
    coord_t          qy_reg;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [3:0]      slot_index_reg;
    logic            new_slot_reg;
    logic            overflow_reg;
    logic [15:0]     active_mask_reg;

    logic            accept;
    logic            done;
    logic            full;
    commit_t         commit;
    best_t           chain [NUM_SLOTS+1];
    cell_stat_t      stat [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] used_vec;
    logic [NUM_SLOTS-1:0] claimed_vec;
    logic [NUM_SLOTS-1:0] active_vec;
    logic [NUM_SLOTS-1:0] mask_next;
    logic [MaskW-1:0]     mask_wide;
    logic [PadIdxW-1:0]   idx_wide;
    logic                 fresh;
    logic                 ovf;

    // --- handshake and sequencing ---
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    // commit once the chain has settled and the result register is free
    assign done     = (state_reg == ST_RUN) && (cnt_reg == SeqW'(LastCnt))
                      && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
                else if (cnt_reg != SeqW'(LastCnt))
                begin
                    cnt_next = cnt_reg + SeqW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // query held for the whole transaction, coordinates wrap to the stored width
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            qx_reg   <= centroid_x[CoordW-1:0];
            qy_reg   <= centroid_y[CoordW-1:0];
        end
    end

    // --- chain of slot cells ---
    assign chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++)
        begin : g_cell
            gnsm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .my_idx   (IdxW'(gi)),
                .qx       (qx_reg),
                .qy       (qy_reg),
                .commit   (commit),
                .best_in  (chain[gi]),
                .best_out (chain[gi+1]),
                .stat     (stat[gi])
            );
            assign used_vec[gi]    = stat[gi].used;
            assign claimed_vec[gi] = stat[gi].claimed;
            assign active_vec[gi]  = stat[gi].active;
        end
    endgenerate

    // --- decision at the end of the chain ---
    assign full = (in_use_reg == CntW'(NUM_SLOTS));

    always_comb
    begin
        commit.en   = done;
        commit.eof  = kind_reg;
        commit.wr   = 1'b0;
        commit.idx  = '0;
        fresh       = 1'b0;
        ovf         = 1'b0;
        in_use_next = in_use_reg;
        if (!kind_reg)
        begin
            if (chain[NUM_SLOTS].found)
            begin
                // nearest unclaimed slot
                commit.wr  = 1'b1;
                commit.idx = chain[NUM_SLOTS].idx;
            end
            else if (!full)
            begin
                // every used slot claimed, allocate the next one
                commit.wr   = 1'b1;
                commit.idx  = in_use_reg[IdxW-1:0];
                fresh       = 1'b1;
                in_use_next = in_use_reg + CntW'(1);
            end
            else
            begin
                ovf = 1'b1;
            end
        end
    end

    // active mask as it stands after the commit
    always_comb
    begin
        if (kind_reg)
        begin
            mask_next = active_vec & (claimed_vec | ~used_vec);
        end
        else if (commit.wr)
        begin
            mask_next = active_vec | (NUM_SLOTS'(1) << commit.idx);
        end
        else
        begin
            mask_next = active_vec;
        end
    end

    assign mask_wide = MaskW'(mask_next);
    assign idx_wide  = PadIdxW'(commit.idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
        end
        else if (done)
        begin
            in_use_reg <= in_use_next;
        end
    end

    // --- result register ---
    assign out_valid_next = done ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            slot_index_reg  <= idx_wide[3:0];
            new_slot_reg    <= fresh;
            overflow_reg    <= ovf;
            active_mask_reg <= mask_wide[15:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign slot_index  = slot_index_reg;
    assign new_slot    = new_slot_reg;
    assign overflow    = overflow_reg;
    assign active_mask = active_mask_reg;

endmodule

FILE: rtl/core/gnsm_cell.sv
// gnsm_cell: one slot of the matcher chain, stores a centroid and its flags
// computes its squared distance to the query and forwards the best candidate
// depends on gnsm_pkg
module gnsm_cell
    import gnsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  idx_t       my_idx,
    input  coord_t     qx,
    input  coord_t     qy,
    input  commit_t    commit,
    input  best_t      best_in,
    output best_t      best_out,
    output cell_stat_t stat
);

    coord_t cx_reg;
    coord_t cy_reg;
    sq_t    sqx_reg;
    sq_t    sqy_reg;
    dist_t  dist_reg;
    logic   used_reg;
    logic   claimed_reg;
    logic   active_reg;
    best_t  best_reg;
    best_t  best_next;

    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [SqW-1:0]   px;
    logic signed [SqW-1:0]   py;
    logic                    elig;
    logic                    hit;

    assign dx = {cx_reg[CoordW-1], cx_reg} - {qx[CoordW-1], qx};
    assign dy = {cy_reg[CoordW-1], cy_reg} - {qy[CoordW-1], qy};
    assign px = dx * dx;
    assign py = dy * dy;

    // squares, then their sum, each behind a register
    always_ff @(posedge clk)
    begin
        sqx_reg  <= $unsigned(px);
        sqy_reg  <= $unsigned(py);
        dist_reg <= DistW'(sqx_reg) + DistW'(sqy_reg);
    end

    assign elig = used_reg && !claimed_reg;
    assign hit  = commit.wr && (commit.idx == my_idx);

    // strict less keeps the lower index on a tie
    always_comb
    begin
        best_next = best_in;
        if (elig && (!best_in.found || (dist_reg < best_in.dist_sq)))
        begin
            best_next.found   = 1'b1;
            best_next.dist_sq = dist_reg;
            best_next.idx     = my_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 1'b0;
            claimed_reg <= 1'b0;
            active_reg  <= 1'b0;
        end
        else if (commit.en)
        begin
            if (commit.eof)
            begin
                active_reg  <= active_reg && (claimed_reg || !used_reg);
                claimed_reg <= 1'b0;
            end
            else if (hit)
            begin
                used_reg    <= 1'b1;
                claimed_reg <= 1'b1;
                active_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit.en && !commit.eof && hit)
        begin
            cx_reg <= qx;
            cy_reg <= qy;
        end
    end

    assign best_out     = best_reg;
    assign stat.used    = used_reg;
    assign stat.claimed = claimed_reg;
    assign stat.active  = active_reg;

endmodule
